// ===== design/cfr_plus_regret_table_engine_defines.svh =====
// ---------------------------------------------------------------------------
// cfr_plus_regret_table_engine_defines.svh
// Assertion macros used by the regret table engine datapath.
// ---------------------------------------------------------------------------
`ifndef CFR_PLUS_REGRET_TABLE_ENGINE_DEFINES_SVH
`define CFR_PLUS_REGRET_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfr engine check failed");

// next-cycle implication, disabled in reset
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfr engine check failed");

`endif

// ===== design/cfr_pkg.sv =====
// ---------------------------------------------------------------------------
// cfr_pkg
// Shared types, widths and codes of the regret table engine.
// ---------------------------------------------------------------------------
package cfr_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_ACTIONS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int BASE_W  = 12;
    localparam int ACT_W   = 4;
    localparam int TOTAL_W = 5;
    localparam int DATA_W  = 32;
    localparam int PROB_W  = 17;
    localparam int SUM_W   = 37;   // 31 entries of 32 bits
    localparam int NUM_W   = 49;   // entry * 2^16 + sum / 2
    localparam int PROD_W  = DATA_W + PROB_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [DATA_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_REGRET_UPD = 2'd0;
    localparam logic [OP_W-1:0] OP_STRAT_ACC  = 2'd1;
    localparam logic [OP_W-1:0] OP_REGRET_MAT = 2'd2;
    localparam logic [OP_W-1:0] OP_AVG_STRAT  = 2'd3;

    localparam logic [1:0] EMIT_UPD   = 2'd0;
    localparam logic [1:0] EMIT_RDERR = 2'd1;
    localparam logic [1:0] EMIT_PROB  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       k_clr;
        logic       k_inc;
        logic       acc_en;
        logic       wr;
        logic       div_load;
        logic       div_step;
        logic       emit;
        logic [1:0] emit_kind;
    } cfr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_update;
        logic upd_err;
        logic rd_err;
        logic k_last;
        logic div_done;
        logic out_free;
    } cfr_sts_t;

endpackage

// ===== design/cfr_plus_regret_table_engine.sv =====
// ---------------------------------------------------------------------------
// cfr_plus_regret_table_engine
// CFR+ regret and strategy sum tables with regret matching.
// ---------------------------------------------------------------------------
// After reset the engine clears both tables, one entry per cycle, with
// in_ready low. It then serves one request at a time. An update goes
// through check, read, modify and write through the registered RAM port,
// and result. A block read of N actions makes a summing pass over the
// entries and then a second pass with, per action, RAM read, divider
// load, the 17-step restoring divider with its done cycle, and the result.
// A result sits in an output register, so the engine moves on while it
// waits; a stalled output holds the engine only when the next result is
// ready.
// ---------------------------------------------------------------------------
module cfr_plus_regret_table_engine #(
    parameter int TABLE_DEPTH = cfr_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_ACTIONS = cfr_pkg::MAX_ACTIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cfr_pkg::OP_W-1:0]          operation,
    input  logic [cfr_pkg::BASE_W-1:0]        base_offset,
    input  logic [cfr_pkg::ACT_W-1:0]         action_number,
    input  logic [cfr_pkg::TOTAL_W-1:0]       action_total,
    input  logic signed [cfr_pkg::DATA_W-1:0] regret_delta,
    input  logic [cfr_pkg::PROB_W-1:0]        action_probability,
    input  logic [cfr_pkg::DATA_W-1:0]        visit_weight,
    input  logic                              regret_only,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cfr_pkg::PROB_W-1:0]        probability,
    output logic [cfr_pkg::ACT_W-1:0]         result_action,
    output logic                              last,
    output logic                              status
);
    import cfr_pkg::*;

    cfr_cmd_t cmd;
    cfr_sts_t sts;

    cfr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_ACTIONS (MAX_ACTIONS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .operation          (operation),
        .base_offset        (base_offset),
        .action_number      (action_number),
        .action_total       (action_total),
        .regret_delta       (regret_delta),
        .action_probability (action_probability),
        .visit_weight       (visit_weight),
        .regret_only        (regret_only),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .probability        (probability),
        .result_action      (result_action),
        .last               (last),
        .status             (status)
    );

endmodule

// ===== design/cfr_ram.sv =====
// ---------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cfr_datapath.sv =====
// ---------------------------------------------------------------------------
// cfr_datapath
// Request registers, both sum tables, update arithmetic, block accumulator,
// restoring divider and the result register.
// ---------------------------------------------------------------------------
`include "cfr_plus_regret_table_engine_defines.svh"

module cfr_datapath #(
    parameter int TABLE_DEPTH = cfr_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_ACTIONS = cfr_pkg::MAX_ACTIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfr_pkg::cfr_cmd_t             cmd,
    output cfr_pkg::cfr_sts_t             sts,
    input  logic [cfr_pkg::OP_W-1:0]      operation,
    input  logic [cfr_pkg::BASE_W-1:0]    base_offset,
    input  logic [cfr_pkg::ACT_W-1:0]     action_number,
    input  logic [cfr_pkg::TOTAL_W-1:0]   action_total,
    input  logic signed [cfr_pkg::DATA_W-1:0] regret_delta,
    input  logic [cfr_pkg::PROB_W-1:0]    action_probability,
    input  logic [cfr_pkg::DATA_W-1:0]    visit_weight,
    input  logic                          regret_only,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cfr_pkg::PROB_W-1:0]    probability,
    output logic [cfr_pkg::ACT_W-1:0]     result_action,
    output logic                          last,
    output logic                          status
);
    import cfr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = ((AW > BASE_W) ? AW : BASE_W) + 2;

    // request registers
    logic [OP_W-1:0]    op_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [DATA_W-1:0]  delta_reg;
    logic [PROB_W-1:0]  prob_reg;
    logic [DATA_W-1:0]  weight_reg;
    logic               sel_strat_reg;

    logic [AW-1:0]      clr_cnt_reg;
    logic [TOTAL_W-1:0] k_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [SUM_W-1:0]     rem_reg;
    logic [PROB_W-1:0]    nlo_reg;
    logic [SUM_W-1:0]     den_reg;
    logic [PROB_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic               out_valid_reg;
    logic [PROB_W-1:0]  prob_out_reg;
    logic [ACT_W-1:0]   act_out_reg;
    logic               last_out_reg;
    logic               status_out_reg;

    logic               is_update;
    logic               upd_err;
    logic               rd_err;
    logic [IW-1:0]      upd_idx;
    logic [IW-1:0]      blk_end;
    logic [IW-1:0]      rd_idx;
    logic [AW-1:0]      addr;
    logic [DATA_W-1:0]  regret_rdata;
    logic [DATA_W-1:0]  strat_rdata;
    logic [DATA_W-1:0]  rdata;
    logic [DATA_W-1:0]  wdata;
    logic               regret_we;
    logic               strat_we;
    logic signed [DATA_W+1:0] regret_total;
    logic [DATA_W+1:0]  strat_sum;
    logic [NUM_W-1:0]   num;
    logic [SUM_W:0]     trial;
    logic               ge;
    logic [PROB_W-1:0]  prob_clamped;

    assign is_update = (op_reg == OP_REGRET_UPD) || (op_reg == OP_STRAT_ACC);
    assign upd_idx   = IW'(base_reg) + IW'(act_reg);
    assign blk_end   = IW'(base_reg) + IW'(total_reg);
    assign rd_idx    = IW'(base_reg) + IW'(k_reg);
    assign upd_err   = ({1'b0, act_reg} >= total_reg) || (upd_idx >= IW'(TABLE_DEPTH));
    assign rd_err    = (total_reg == '0) || (IW'(total_reg) > IW'(MAX_ACTIONS))
                     || (blk_end > IW'(TABLE_DEPTH));

    assign addr = cmd.clr_step ? clr_cnt_reg
                : (is_update ? AW'(upd_idx) : AW'(rd_idx));

    assign rdata = sel_strat_reg ? strat_rdata : regret_rdata;

    // regret: exact signed add, clamp at zero, saturate at the top
    assign regret_total = $signed({2'b00, rdata})
                        + $signed({{2{delta_reg[DATA_W-1]}}, delta_reg});
    assign strat_sum  = {2'b00, rdata} + {1'b0, prod_reg[PROD_W-1:16]};

    always_comb
    begin
        wdata = '0;
        if (!cmd.clr_step)
        begin
            if (op_reg == OP_REGRET_UPD)
            begin
                if (regret_total[DATA_W+1])
                    wdata = '0;
                else if (regret_total[DATA_W])
                    wdata = SUM_MAX;
                else
                    wdata = regret_total[DATA_W-1:0];
            end
            else
            begin
                wdata = (strat_sum[DATA_W+1:DATA_W] != 2'b00) ? SUM_MAX
                                                              : strat_sum[DATA_W-1:0];
            end
        end
    end

    assign regret_we = cmd.clr_step || (cmd.wr && !sel_strat_reg);
    assign strat_we  = cmd.clr_step || (cmd.wr && sel_strat_reg);

    cfr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_regret_ram (
        .clk   (clk),
        .we    (regret_we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (regret_rdata)
    );

    cfr_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_strat_ram (
        .clk   (clk),
        .we    (strat_we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (strat_rdata)
    );

    assign prob_clamped = (action_probability > ONE_Q16) ? ONE_Q16 : action_probability;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= operation;
            base_reg      <= base_offset;
            act_reg       <= action_number;
            total_reg     <= action_total;
            delta_reg     <= regret_delta;
            prob_reg      <= prob_clamped;
            weight_reg    <= visit_weight;
            sel_strat_reg <= (operation == OP_STRAT_ACC)
                          || ((operation == OP_AVG_STRAT) && !regret_only);
        end
        prod_reg <= PROD_W'(weight_reg) * PROD_W'(prob_reg);
        if (cmd.load)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_reg + SUM_W'(rdata);
    end

    // zero sum: uniform share through the same divider
    assign num = (acc_reg == '0) ? NUM_W'(ONE_Q16)
               : ({rdata, 16'h0000} + NUM_W'(acc_reg >> 1));

    assign trial = {rem_reg, nlo_reg[PROB_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.k_clr)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + 1'b1;
            if (cmd.div_load)
                div_cnt_reg <= DIV_CNT_W'(PROB_W);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg <= SUM_W'(num[NUM_W-1:PROB_W]);
            nlo_reg <= num[PROB_W-1:0];
            den_reg <= (acc_reg == '0) ? SUM_W'(total_reg) : acc_reg;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? SUM_W'(trial - {1'b0, den_reg}) : trial[SUM_W-1:0];
            nlo_reg <= {nlo_reg[PROB_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PROB_W-2:0], ge};
        end
        if (cmd.emit)
        begin
            case (cmd.emit_kind)
                EMIT_UPD:
                begin
                    prob_out_reg   <= '0;
                    act_out_reg    <= act_reg;
                    last_out_reg   <= 1'b1;
                    status_out_reg <= upd_err;
                end
                EMIT_PROB:
                begin
                    prob_out_reg   <= quo_reg;
                    act_out_reg    <= k_reg[ACT_W-1:0];
                    last_out_reg   <= sts.k_last;
                    status_out_reg <= 1'b0;
                end
                default:
                begin
                    prob_out_reg   <= '0;
                    act_out_reg    <= '0;
                    last_out_reg   <= 1'b1;
                    status_out_reg <= 1'b1;
                end
            endcase
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == AW'(TABLE_DEPTH - 1));
    assign sts.is_update = is_update;
    assign sts.upd_err   = upd_err;
    assign sts.rd_err    = rd_err;
    assign sts.k_last    = (k_reg == total_reg - 1'b1);
    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign probability   = prob_out_reg;
    assign result_action = act_out_reg;
    assign last          = last_out_reg;
    assign status        = status_out_reg;

    `CFR_ASSERT_NOW(a_emit_slot_free, cmd.emit, sts.out_free)
    `CFR_ASSERT_NOW(a_no_write_on_err, cmd.wr, !upd_err && is_update)
    `CFR_ASSERT_NOW(a_step_in_range, cmd.div_step, div_cnt_reg != '0)
    `CFR_ASSERT_NOW(a_prob_after_div, cmd.emit && (cmd.emit_kind == EMIT_PROB),
                    div_cnt_reg == '0)
    `CFR_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_reg)

endmodule

// ===== design/cfr_controller.sv =====
// ---------------------------------------------------------------------------
// cfr_controller
// Sequencer of the regret table engine: clearing pass, updates and the
// two-pass block read with per-entry division.
// ---------------------------------------------------------------------------
module cfr_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfr_pkg::cfr_sts_t sts,
    output cfr_pkg::cfr_cmd_t cmd
);
    import cfr_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_U_RD  = 4'd3;
    localparam logic [3:0] ST_U_WR  = 4'd4;
    localparam logic [3:0] ST_E_UPD = 4'd5;
    localparam logic [3:0] ST_E_RDE = 4'd6;
    localparam logic [3:0] ST_S_RD  = 4'd7;
    localparam logic [3:0] ST_S_ACC = 4'd8;
    localparam logic [3:0] ST_D_RD  = 4'd9;
    localparam logic [3:0] ST_D_LD  = 4'd10;
    localparam logic [3:0] ST_D_RUN = 4'd11;
    localparam logic [3:0] ST_E_PRB = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = EMIT_UPD;
        in_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.is_update)
                    state_next = sts.upd_err ? ST_E_UPD : ST_U_RD;
                else
                    state_next = sts.rd_err ? ST_E_RDE : ST_S_RD;
            end
            ST_U_RD:
                state_next = ST_U_WR;
            ST_U_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_E_UPD;
            end
            ST_E_UPD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_E_RDE:
            begin
                cmd.emit_kind = EMIT_RDERR;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD:
                state_next = ST_S_ACC;
            ST_S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (sts.k_last)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = ST_D_RD;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_D_RD:
                state_next = ST_D_LD;
            ST_D_LD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_D_RUN;
            end
            ST_D_RUN:
            begin
                if (sts.div_done)
                    state_next = ST_E_PRB;
                else
                    cmd.div_step = 1'b1;
            end
            ST_E_PRB:
            begin
                cmd.emit_kind = EMIT_PROB;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.k_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_D_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
